// ===== rtl/core/fpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and constants for the fixed-point atan2 block
// Input widths, Q15 constants, pipeline control word and divider step.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int InW    = 11;   // input component width
  localparam int OutW   = 9;    // angle width
  localparam int QBits  = 16;   // quotient magnitude bits (up to 2^15)
  localparam int RemW   = 12;   // divider remainder / divisor width
  localparam int DivSt  = 4;    // divider pipeline stages
  localparam int DivPer = QBits / DivSt;  // quotient bits per stage

  localparam logic signed [7:0] LinCoef = -8'sd56;
  localparam logic signed [7:0] CubCoef = 8'sd11;
  localparam logic signed [9:0] OfsRight = 10'sd45;
  localparam logic signed [9:0] OfsLeft  = 10'sd135;
  localparam logic signed [9:0] FullTurn = 10'sd360;
  localparam logic [OutW-1:0]   HalfTurn = 9'd180;
  localparam logic [OutW-1:0]   ZeroAng  = 9'd0;

  // control bits that travel with each item
  typedef struct packed {
    logic y_zero;
    logic y_neg;
    logic x_neg;
    logic q_neg;
  } ctl_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [QBits-1:0] q;
  } div_t;

  // DivPer restoring steps; the very first step of the whole division
  // compares without a shift to produce the integer bit.
  function automatic div_t div_steps(input logic [RemW-1:0]  rem_in,
                                     input logic [QBits-1:0] q_in,
                                     input logic [RemW-1:0]  den,
                                     input logic             first);
    div_t res;
    res.rem = rem_in;
    res.q   = q_in;
    for (int i = 0; i < DivPer; i++) begin
      if (!(first && (i == 0))) begin
        res.rem = {res.rem[RemW-2:0], 1'b0};
      end
      if (res.rem >= den) begin
        res.rem = res.rem - den;
        res.q   = {res.q[QBits-2:0], 1'b1};
      end else begin
        res.q   = {res.q[QBits-2:0], 1'b0};
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/fixed_point_atan2_degrees_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_atan2_degrees_top: pipelined atan2 in whole degrees
// Q15 ratio by pipelined division, cubic fit, quadrant fix-up.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: in_x_value / in_y_value (11-bit signed) with in_valid /
//   in_ready. Result channel: out_angle_degrees (0..360) with out_valid /
//   out_ready. Each item gives exactly one result, in order.
//   Throughput: one item per cycle while the output register is not stalled;
//   the whole pipe moves as one, a shift of nine stage registers, of which
//   four are the restoring divider (four quotient bits a stage) and three
//   the Q15 ratio, the square multiply and the cube multiply.
//   Stall: while a result sits unaccepted in the output register, every
//   stage holds (in_ready low); nothing is dropped or repeated. in_ready
//   is high whenever the output register is empty or being taken.
//   Reset (rst_n low, synchronous) clears all valid bits; payload
//   registers are not reset.
//   Zero vertical component bypasses the maths: 0 for x >= 0, else 180.
// ----------------------------------------------------------------------------
module fixed_point_atan2_degrees_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [fpa_pkg::InW-1:0]  in_x_value,
  input  logic signed [fpa_pkg::InW-1:0]  in_y_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic        [fpa_pkg::OutW-1:0] out_angle_degrees
);

  localparam int NStg = fpa_pkg::DivSt + 5;  // valid bits incl. output reg
  localparam int NCtl = NStg - 1;            // control travels to last stage

  logic                 adv;
  logic [NStg-1:0]      v_r;
  logic [NStg-1:0]      v_nxt;
  fpa_pkg::ctl_t        ctl_r [NCtl];
  fpa_pkg::ctl_t        ctl_nxt;

  // divider stage registers; index 0 is the input stage
  logic [fpa_pkg::RemW-1:0]  dv_rem_r [fpa_pkg::DivSt+1];
  logic [fpa_pkg::QBits-1:0] dv_q_r   [fpa_pkg::DivSt+1];
  logic [fpa_pkg::RemW-1:0]  dv_den_r [fpa_pkg::DivSt+1];
  fpa_pkg::div_t             dv_nxt   [fpa_pkg::DivSt+1];

  // input stage arithmetic
  logic signed [12:0] x13;
  logic signed [12:0] ay13;
  logic signed [12:0] num13;
  logic signed [12:0] den13;
  logic signed [12:0] nmag13;

  // ratio and polynomial stages
  logic signed [16:0] r_nxt;
  logic signed [16:0] r5_r;
  logic signed [33:0] sq_prod;
  logic        [15:0] r2_r;
  logic signed [16:0] r6_r;
  logic signed [22:0] lin_nxt;
  logic signed [22:0] lin6_r;
  logic signed [33:0] cu_prod;
  logic signed [16:0] r3_r;
  logic signed [22:0] lin7_r;
  logic signed [22:0] sum_w;
  logic signed [9:0]  ang_w;
  logic signed [9:0]  fin_w;
  logic [fpa_pkg::OutW-1:0] ang_nxt;
  logic [fpa_pkg::OutW-1:0] out_ang_r;

  assign adv      = !v_r[NStg-1] || out_ready;
  assign in_ready = adv;
  assign v_nxt    = {v_r[NStg-2:0], in_valid};

  // --- input stage: reduce to |num| / den with num magnitude <= den ---
  always_comb begin
    x13  = 13'(in_x_value);
    ay13 = in_y_value[fpa_pkg::InW-1] ? -13'(in_y_value) : 13'(in_y_value);
    if (!in_x_value[fpa_pkg::InW-1]) begin
      num13 = x13 - ay13;
      den13 = x13 + ay13;
    end else begin
      num13 = x13 + ay13;
      den13 = ay13 - x13;
    end
    nmag13         = num13[12] ? -num13 : num13;
    ctl_nxt.y_zero = (in_y_value == '0);
    ctl_nxt.y_neg  = in_y_value[fpa_pkg::InW-1];
    ctl_nxt.x_neg  = in_x_value[fpa_pkg::InW-1];
    ctl_nxt.q_neg  = num13[12];
  end

  always_comb begin
    dv_nxt[0] = '0;
    for (int k = 1; k <= fpa_pkg::DivSt; k++) begin
      dv_nxt[k] = fpa_pkg::div_steps(dv_rem_r[k-1], dv_q_r[k-1], dv_den_r[k-1],
                                     (k == 1));
    end
  end

  // --- ratio, square, cube ---
  assign r_nxt   = ctl_r[fpa_pkg::DivSt].q_neg ?
                   -$signed({1'b0, dv_q_r[fpa_pkg::DivSt]}) :
                    $signed({1'b0, dv_q_r[fpa_pkg::DivSt]});
  assign sq_prod = 34'(r5_r) * 34'(r5_r);
  assign lin_nxt = 23'(r5_r) * 23'(fpa_pkg::LinCoef);
  assign cu_prod = 34'($signed({1'b0, r2_r})) * 34'(r6_r);

  // --- final sum, floor shift and quadrant fix-up ---
  always_comb begin
    sum_w = lin7_r + 23'(r3_r) * 23'(fpa_pkg::CubCoef);
    ang_w = (ctl_r[NCtl-1].x_neg ? fpa_pkg::OfsLeft : fpa_pkg::OfsRight)
            + 10'($signed(sum_w[22:15]));
    fin_w = ctl_r[NCtl-1].y_neg ? (fpa_pkg::FullTurn - ang_w) : ang_w;
    if (ctl_r[NCtl-1].y_zero) begin
      ang_nxt = ctl_r[NCtl-1].x_neg ? fpa_pkg::HalfTurn : fpa_pkg::ZeroAng;
    end else begin
      ang_nxt = fin_w[fpa_pkg::OutW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r[0]    <= ctl_nxt;
      dv_rem_r[0] <= nmag13[fpa_pkg::RemW-1:0];
      dv_q_r[0]   <= '0;
      dv_den_r[0] <= den13[fpa_pkg::RemW-1:0];
      for (int k = 1; k < NCtl; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
      for (int k = 1; k <= fpa_pkg::DivSt; k++) begin
        dv_rem_r[k] <= dv_nxt[k].rem;
        dv_q_r[k]   <= dv_nxt[k].q;
        dv_den_r[k] <= dv_den_r[k-1];
      end
      r5_r      <= r_nxt;
      r2_r      <= sq_prod[30:15];
      r6_r      <= r5_r;
      lin6_r    <= lin_nxt;
      r3_r      <= cu_prod[31:15];
      lin7_r    <= lin6_r;
      out_ang_r <= ang_nxt;
    end
  end

  assign out_valid         = v_r[NStg-1];
  assign out_angle_degrees = out_ang_r;

  // --- checks ---
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r))
    else $error("pipeline moved while stalled");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[fpa_pkg::DivSt] && !ctl_r[fpa_pkg::DivSt].y_zero |->
      (dv_rem_r[fpa_pkg::DivSt] < dv_den_r[fpa_pkg::DivSt]))
    else $error("divider remainder not below divisor");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[fpa_pkg::DivSt+1] && !ctl_r[fpa_pkg::DivSt+1].y_zero |->
      (r5_r <= 17'sd32768) && (r5_r >= -17'sd32768))
    else $error("Q15 ratio out of range");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle_degrees <= 9'd360))
    else $error("angle above full turn");

endmodule
